// File: sv/fixed_point_conv5x5_line_buffer_unit_assert.svh
// Assertion macros shared by the convolution unit RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef FIXED_POINT_CONV5X5_LINE_BUFFER_UNIT_ASSERT_SVH
`define FIXED_POINT_CONV5X5_LINE_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ccl_pkg.sv
// Shared constants, types and codes for the 5x5 convolution unit.
// Depends on nothing; used by ccl_mac and the top level.
package ccl_pkg;

  // Geometry.
  localparam int IMAGE_WIDTH  = 32;
  localparam int KERNEL_WIDTH = 5;
  localparam int MAP_COUNT    = 6;
  localparam int TAPS         = KERNEL_WIDTH * KERNEL_WIDTH;

  // Field widths fixed by the interface.
  localparam int OP_W      = 2;
  localparam int MAP_W     = 3;
  localparam int TAP_W     = 5;
  localparam int DATA_W    = 16;
  localparam int SHIFT_W   = 4;
  localparam int OUT_POS_W = 5;
  localparam int PROD_W    = 2 * DATA_W;

  // Storage sizes and derived index widths.
  localparam int W_DEPTH  = MAP_COUNT * TAPS;
  localparam int LS_DEPTH = KERNEL_WIDTH * IMAGE_WIDTH;
  localparam int W_AW     = $clog2(W_DEPTH);
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int POS_W    = $clog2(IMAGE_WIDTH);
  localparam int KS_W     = $clog2(KERNEL_WIDTH);
  localparam int BIAS_AW  = (MAP_COUNT > 1) ? $clog2(MAP_COUNT) : 1;

  localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RESET = 4'd8;

  // Input operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_PIXEL  = 2'd2
  } op_t;

  // Control from the sequencer to the shared multiply-accumulate unit.
  typedef struct packed {
    logic load;   // Preload the accumulator with the bias.
    logic valid;  // Pixel and weight operands are present this cycle.
  } mac_ctl_t;

endpackage

// File: sv/ccl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module ccl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share one clock.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ccl_mac.sv
// Shared multiply, shift and accumulate unit used once per kernel tap.
// Depends on ccl_pkg.
module ccl_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ccl_pkg::mac_ctl_t             ctl,
  input  logic [ccl_pkg::DATA_W-1:0]    bias,
  input  logic [ccl_pkg::DATA_W-1:0]    pixel,
  input  logic [ccl_pkg::DATA_W-1:0]    weight,
  input  logic [ccl_pkg::SHIFT_W-1:0]   shift,
  output logic [ccl_pkg::DATA_W-1:0]    acc,
  output logic                          busy
);

  logic signed [ccl_pkg::PROD_W-1:0] prod_r;
  logic                              prod_v_r;
  logic signed [ccl_pkg::PROD_W-1:0] shifted;
  logic        [ccl_pkg::DATA_W-1:0] acc_r;

  // Arithmetic shift of the registered product; only the low bits feed the wrapping sum.
  assign shifted = prod_r >>> shift;

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.valid;
    end
    prod_r <= $signed(pixel) * $signed(weight);
  end

  // Accumulate stage, preloaded with the bias of the current map.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= bias;
    end else if (prod_v_r) begin
      acc_r <= acc_r + shifted[ccl_pkg::DATA_W-1:0];
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule

// File: sv/fixed_point_conv5x5_line_buffer_unit.sv
// Top level of the 5x5 fixed-point convolution unit with a rolling line store.
// Depends on ccl_pkg, ccl_ram, ccl_mac and the assertion macro header.
//
//  Channel | Handshake             | Beat contents
//  in      | in_valid / in_ready   | operation, map, tap, data, image start
//  out     | out_valid / out_ready | map, row, column, value, last
//  cfg     | cfg_wr_en             | frac_shift (4 bits)
//
// Weight loads, bias loads and pixels without a full window leave the unit idle.
// A pixel that completes a window closes the input until every map is done: one shared
// multiplier handles one tap per cycle, plus a bias preload and a drain per map.
// Reset is synchronous; weights, biases and the line store hold garbage until written.
// A stalled result holds the unit only when the next map's result is ready to load.
module fixed_point_conv5x5_line_buffer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ccl_pkg::OP_W-1:0]      in_operation,
  input  logic [ccl_pkg::MAP_W-1:0]     in_map_index,
  input  logic [ccl_pkg::TAP_W-1:0]     in_tap_index,
  input  logic signed [ccl_pkg::DATA_W-1:0] in_data_value,
  input  logic                          in_image_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ccl_pkg::MAP_W-1:0]     out_map,
  output logic [ccl_pkg::OUT_POS_W-1:0] out_row,
  output logic [ccl_pkg::OUT_POS_W-1:0] out_col,
  output logic signed [ccl_pkg::DATA_W-1:0] out_value,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [ccl_pkg::SHIFT_W-1:0]   cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIAS,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                              state_r;
  logic [ccl_pkg::SHIFT_W-1:0]         frac_r;
  logic [ccl_pkg::POS_W-1:0]           row_r;
  logic [ccl_pkg::POS_W-1:0]           col_r;
  logic [ccl_pkg::KS_W-1:0]            slot_r;
  logic [ccl_pkg::POS_W-1:0]           r0_r;
  logic [ccl_pkg::POS_W-1:0]           c0_r;
  logic [ccl_pkg::KS_W-1:0]            kbase_r;
  logic [ccl_pkg::KS_W-1:0]            kslot_r;
  logic [ccl_pkg::KS_W-1:0]            kr_r;
  logic [ccl_pkg::KS_W-1:0]            kc_r;
  logic [ccl_pkg::BIAS_AW-1:0]         map_r;
  logic [ccl_pkg::W_AW-1:0]            waddr_r;
  logic                                rd_v_r;
  logic [ccl_pkg::DATA_W-1:0]          bias_r [ccl_pkg::MAP_COUNT];
  logic                                out_valid_r;
  logic [ccl_pkg::MAP_W-1:0]           out_map_r;
  logic [ccl_pkg::OUT_POS_W-1:0]       out_row_r;
  logic [ccl_pkg::OUT_POS_W-1:0]       out_col_r;
  logic [ccl_pkg::DATA_W-1:0]          out_value_r;
  logic                                out_last_r;

  logic                                in_fire;
  logic                                w_we;
  logic                                b_we;
  logic                                px_fire;
  logic [ccl_pkg::W_AW-1:0]            w_waddr;
  logic [ccl_pkg::BIAS_AW-1:0]         b_idx;
  logic [ccl_pkg::POS_W-1:0]           eff_row;
  logic [ccl_pkg::POS_W-1:0]           eff_col;
  logic [ccl_pkg::KS_W-1:0]            eff_slot;
  logic                                win;
  logic [ccl_pkg::LS_AW-1:0]           ls_waddr;
  logic [ccl_pkg::LS_AW-1:0]           ls_raddr;
  logic [ccl_pkg::DATA_W-1:0]          ls_rdata;
  logic [ccl_pkg::DATA_W-1:0]          w_rdata;
  logic [ccl_pkg::DATA_W-1:0]          acc;
  logic                                mac_busy;
  ccl_pkg::mac_ctl_t                   mac_ctl;
  logic                                out_load;
  logic [ccl_pkg::OUT_POS_W+ccl_pkg::POS_W-1:0] r0_ext;
  logic [ccl_pkg::OUT_POS_W+ccl_pkg::POS_W-1:0] c0_ext;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Operation decode for the accepted beat; out-of-range loads and code 3 do nothing.
  always_comb begin
    w_we    = 1'b0;
    b_we    = 1'b0;
    px_fire = 1'b0;
    case (ccl_pkg::op_t'(in_operation))
      ccl_pkg::OP_WEIGHT: begin
        w_we = in_fire && (int'(in_map_index) < ccl_pkg::MAP_COUNT)
                       && (int'(in_tap_index) < ccl_pkg::TAPS);
      end
      ccl_pkg::OP_BIAS: begin
        b_we = in_fire && (int'(in_map_index) < ccl_pkg::MAP_COUNT);
      end
      ccl_pkg::OP_PIXEL: begin
        px_fire = in_fire;
      end
      default: begin
        px_fire = 1'b0;
      end
    endcase
  end

  assign w_waddr = ccl_pkg::W_AW'(in_map_index) * ccl_pkg::W_AW'(ccl_pkg::TAPS)
                 + ccl_pkg::W_AW'(in_tap_index);
  assign b_idx   = ccl_pkg::BIAS_AW'(in_map_index);

  // Position of the incoming pixel; image start forces the top-left corner.
  assign eff_row  = in_image_start ? '0 : row_r;
  assign eff_col  = in_image_start ? '0 : col_r;
  assign eff_slot = in_image_start ? '0 : slot_r;
  assign win      = (eff_row >= ccl_pkg::POS_W'(ccl_pkg::KERNEL_WIDTH - 1))
                 && (eff_col >= ccl_pkg::POS_W'(ccl_pkg::KERNEL_WIDTH - 1));

  // Line store addressing: row slot times image width plus column.
  assign ls_waddr = ccl_pkg::LS_AW'(eff_slot) * ccl_pkg::LS_AW'(ccl_pkg::IMAGE_WIDTH)
                  + ccl_pkg::LS_AW'(eff_col);
  assign ls_raddr = ccl_pkg::LS_AW'(kslot_r) * ccl_pkg::LS_AW'(ccl_pkg::IMAGE_WIDTH)
                  + ccl_pkg::LS_AW'(c0_r) + ccl_pkg::LS_AW'(kc_r);

  ccl_ram #(
    .WIDTH (ccl_pkg::DATA_W),
    .DEPTH (ccl_pkg::LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (px_fire),
    .waddr (ls_waddr),
    .wdata (in_data_value),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  ccl_ram #(
    .WIDTH (ccl_pkg::DATA_W),
    .DEPTH (ccl_pkg::W_DEPTH)
  ) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_data_value),
    .raddr (waddr_r),
    .rdata (w_rdata)
  );

  // Shared arithmetic unit.
  assign mac_ctl.load  = (state_r == S_BIAS);
  assign mac_ctl.valid = rd_v_r;

  ccl_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .bias   (bias_r[map_r]),
    .pixel  (ls_rdata),
    .weight (w_rdata),
    .shift  (frac_r),
    .acc    (acc),
    .busy   (mac_busy)
  );

  // A finished map moves to the output register once the pipe is empty and the slot is free.
  assign out_load = (state_r == S_DRAIN) && !rd_v_r && !mac_busy
                 && (!out_valid_r || out_ready);
  assign r0_ext   = {{ccl_pkg::OUT_POS_W{1'b0}}, r0_r};
  assign c0_ext   = {{ccl_pkg::OUT_POS_W{1'b0}}, c0_r};

  // Bias registers.
  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_r[b_idx] <= in_data_value;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_map_r   <= ccl_pkg::MAP_W'(map_r);
      out_row_r   <= r0_ext[ccl_pkg::OUT_POS_W-1:0];
      out_col_r   <= c0_ext[ccl_pkg::OUT_POS_W-1:0];
      out_value_r <= acc;
      out_last_r  <= (map_r == ccl_pkg::BIAS_AW'(ccl_pkg::MAP_COUNT - 1));
    end
  end

  // Sequencer: pixel position, tap counters and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frac_r      <= ccl_pkg::FRAC_SHIFT_RESET;
      row_r       <= '0;
      col_r       <= '0;
      slot_r      <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frac_r <= cfg_wr_data;
      end
      rd_v_r <= (state_r == S_RUN);
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (px_fire) begin
            // Advance the raster position; slots restart with each image.
            if (eff_col == ccl_pkg::POS_W'(ccl_pkg::IMAGE_WIDTH - 1)) begin
              col_r <= '0;
              if (eff_row == ccl_pkg::POS_W'(ccl_pkg::IMAGE_WIDTH - 1)) begin
                row_r  <= '0;
                slot_r <= '0;
              end else begin
                row_r  <= eff_row + 1'b1;
                slot_r <= (eff_slot == ccl_pkg::KS_W'(ccl_pkg::KERNEL_WIDTH - 1)) ?
                          '0 : eff_slot + 1'b1;
              end
            end else begin
              col_r  <= eff_col + 1'b1;
              row_r  <= eff_row;
              slot_r <= eff_slot;
            end
            if (win) begin
              r0_r    <= eff_row - ccl_pkg::POS_W'(ccl_pkg::KERNEL_WIDTH - 1);
              c0_r    <= eff_col - ccl_pkg::POS_W'(ccl_pkg::KERNEL_WIDTH - 1);
              // The oldest window row sits one slot after the newest.
              kbase_r <= (eff_slot == ccl_pkg::KS_W'(ccl_pkg::KERNEL_WIDTH - 1)) ?
                         '0 : eff_slot + 1'b1;
              map_r   <= '0;
              waddr_r <= '0;
              state_r <= S_BIAS;
            end
          end
        end
        S_BIAS: begin
          kr_r    <= '0;
          kc_r    <= '0;
          kslot_r <= kbase_r;
          state_r <= S_RUN;
        end
        S_RUN: begin
          // One tap read per cycle; weights for all maps are stored back to back.
          waddr_r <= waddr_r + 1'b1;
          if (kc_r == ccl_pkg::KS_W'(ccl_pkg::KERNEL_WIDTH - 1)) begin
            kc_r <= '0;
            if (kr_r == ccl_pkg::KS_W'(ccl_pkg::KERNEL_WIDTH - 1)) begin
              state_r <= S_DRAIN;
            end else begin
              kr_r    <= kr_r + 1'b1;
              kslot_r <= (kslot_r == ccl_pkg::KS_W'(ccl_pkg::KERNEL_WIDTH - 1)) ?
                         '0 : kslot_r + 1'b1;
            end
          end else begin
            kc_r <= kc_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            if (map_r == ccl_pkg::BIAS_AW'(ccl_pkg::MAP_COUNT - 1)) begin
              state_r <= S_IDLE;
            end else begin
              map_r   <= map_r + 1'b1;
              state_r <= S_BIAS;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_map   = out_map_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // Checks on the sequencer.
`include "fixed_point_conv5x5_line_buffer_unit_assert.svh"

  `CCL_ASSERT_NOW(a_last_is_final_map, out_valid && out_last, out_map == ccl_pkg::MAP_W'(ccl_pkg::MAP_COUNT - 1), "last beat on a map other than the final one")
  `CCL_ASSERT_NEXT(a_window_blocks_input, px_fire && win, !in_ready, "input still open after a windowed pixel")
  `CCL_ASSERT_NOW(a_read_follows_run, rd_v_r, $past(state_r == S_RUN), "operand valid without a tap read issued")
  `CCL_ASSERT_NOW(a_load_with_empty_pipe, out_load, !mac_busy && !rd_v_r, "result loaded while taps are in flight")

endmodule
